@@ src/stlb_pkg.sv @@
// Shared types and constants for the sorted table lower-bound block.
// Depends on nothing; used by stlb_search and sorted_table_lower_bound_top.
package stlb_pkg;

    // Command codes carried in the command field of an input beat.
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Search sequencer states.
    typedef enum logic [1:0]
    {
        SRCH_IDLE,
        SRCH_PROBE,
        SRCH_FINISH
    } srch_state_t;

    // Requests from the top level to the search sequencer.
    typedef struct packed
    {
        logic start;   // a query beat is accepted this cycle
        logic load;    // the output register takes the finished answer
    } srch_ctl_t;

    // Status returned by the search sequencer.
    typedef struct packed
    {
        logic busy;    // a query is in progress or its answer is pending
        logic done;    // the answer on position is final
    } srch_stat_t;

endpackage

@@ src/sorted_table_lower_bound_top.sv @@
// Top level of the sorted table lower-bound block: entry count register,
// entry RAM, search sequencer and output register.
// Depends on stlb_pkg, stlb_ram and stlb_search.
//
//  Channel  Handshake                Payload
//  -------  -----------------------  ----------------------------------------
//  in       in_valid / in_stall      command, entry_index, entry_value,
//                                    search_key
//  out      out_valid / out_stall    position
//  cfg      cfg_valid / cfg_ready    entry_count
//
// A write beat gives no result. A query issues its first probe in the accepting cycle,
// unless the count is zero, then narrows the range on each returned entry (at most
// floor(log2(count)) + 1 probes, 11 for 1024 entries) and, once the output register is
// free, hands it the answer; the input stalls until that hand-over is done.
// Reset clears the count and control state; the RAM is not cleared.
// A stalled output holds its beat while the next input beat may already run.
module sorted_table_lower_bound_top #(
    parameter int TABLE_DEPTH = 1024,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Input channel.
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                command,
    input  logic [$clog2(TABLE_DEPTH)-1:0]      entry_index,
    input  logic signed [VALUE_WIDTH-1:0]       entry_value,
    input  logic signed [VALUE_WIDTH-1:0]       search_key,
    // Output channel.
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [$clog2(TABLE_DEPTH+1)-1:0]    position,
    // Configuration channel.
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [$clog2(TABLE_DEPTH+1)-1:0]    entry_count
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int POS_W = $clog2(TABLE_DEPTH + 1);

    stlb_pkg::srch_ctl_t  srch_ctl;
    stlb_pkg::srch_stat_t srch_stat;

    logic [POS_W-1:0]              entry_count_reg;
    logic [POS_W-1:0]              count_sat;
    logic                          in_accept;
    logic                          wr_en;
    logic                          rd_en;
    logic [IDX_W-1:0]              rd_addr;
    logic signed [VALUE_WIDTH-1:0] rd_data;
    logic [POS_W-1:0]              srch_position;
    logic                          out_valid_reg, out_valid_next;
    logic [POS_W-1:0]              position_reg;

    // Configuration register, always ready.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            entry_count_reg <= entry_count;
        end
    end

    // Counts beyond the table depth search the whole table.
    assign count_sat = (entry_count_reg > POS_W'(TABLE_DEPTH)) ? POS_W'(TABLE_DEPTH)
                                                             : entry_count_reg;

    // Input handshake: one item at a time.
    assign in_stall  = srch_stat.busy;
    assign in_accept = in_valid && !in_stall;

    // Entry writes; positions beyond the depth are dropped.
    assign wr_en = in_accept && (command == stlb_pkg::CMD_WRITE)
                   && ({1'b0, entry_index} < (IDX_W + 1)'(TABLE_DEPTH));

    stlb_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (TABLE_DEPTH)
    ) u_entries (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (entry_index),
        .wr_data (entry_value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Search sequencer requests.
    always_comb
    begin
        srch_ctl.start = in_accept && (command == stlb_pkg::CMD_QUERY);
        srch_ctl.load  = srch_stat.done && (!out_valid_reg || !out_stall);
    end

    stlb_search #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_search (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (srch_ctl),
        .stat     (srch_stat),
        .key      (search_key),
        .count    (count_sat),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .position (srch_position)
    );

    // Output register: holds a beat until the sink takes it.
    assign out_valid_next = srch_ctl.load || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (srch_ctl.load)
        begin
            position_reg <= srch_position;
        end
    end

    assign out_valid = out_valid_reg;
    assign position  = position_reg;

endmodule

@@ src/stlb_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module stlb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port with a registered output.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ src/stlb_search.sv @@
// Binary search sequencer: keeps the low and high bounds, issues one probe
// read a cycle to the entry RAM and narrows the range on the returned entry.
// Depends on stlb_pkg.
module stlb_search #(
    parameter int TABLE_DEPTH = 1024,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  stlb_pkg::srch_ctl_t               ctl,
    output stlb_pkg::srch_stat_t              stat,
    input  logic signed [VALUE_WIDTH-1:0]     key,
    input  logic [$clog2(TABLE_DEPTH+1)-1:0]  count,
    output logic                              rd_en,
    output logic [$clog2(TABLE_DEPTH)-1:0]    rd_addr,
    input  logic signed [VALUE_WIDTH-1:0]     rd_data,
    output logic [$clog2(TABLE_DEPTH+1)-1:0]  position
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int POS_W = $clog2(TABLE_DEPTH + 1);

    stlb_pkg::srch_state_t state_reg, state_next;

    logic [POS_W-1:0]             low_reg, low_next;
    logic [POS_W-1:0]             high_reg, high_next;
    logic [POS_W-1:0]             mid_reg, mid_next;
    logic signed [VALUE_WIDTH-1:0] key_reg, key_next;

    // Bounds after the probe whose entry has just come back.
    logic             entry_less;
    logic [POS_W-1:0] low_step;
    logic [POS_W-1:0] high_step;
    logic [POS_W:0]   bound_sum;
    logic             range_open;

    always_comb
    begin
        entry_less = rd_data < key_reg;
        low_step   = entry_less ? mid_reg + POS_W'(1) : low_reg;
        high_step  = entry_less ? high_reg : mid_reg;
        bound_sum  = {1'b0, low_step} + {1'b0, high_step};
        range_open = low_step < high_step;
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= stlb_pkg::SRCH_IDLE;
            low_reg   <= '0;
            high_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            low_reg   <= low_next;
            high_reg  <= high_next;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        mid_reg <= mid_next;
        key_reg <= key_next;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            stlb_pkg::SRCH_IDLE:
            begin
                if (ctl.start)
                begin
                    state_next = (count == '0) ? stlb_pkg::SRCH_FINISH
                                               : stlb_pkg::SRCH_PROBE;
                end
            end
            stlb_pkg::SRCH_PROBE:
            begin
                if (!range_open)
                begin
                    state_next = stlb_pkg::SRCH_FINISH;
                end
            end
            stlb_pkg::SRCH_FINISH:
            begin
                if (ctl.load)
                begin
                    state_next = stlb_pkg::SRCH_IDLE;
                end
            end
            default:
            begin
                state_next = stlb_pkg::SRCH_IDLE;
            end
        endcase
    end

    // Bounds, probe address and status.
    always_comb
    begin
        low_next  = low_reg;
        high_next = high_reg;
        mid_next  = mid_reg;
        key_next  = key_reg;
        rd_en     = 1'b0;
        stat.busy = 1'b1;
        stat.done = 1'b0;
        unique case (state_reg)
            stlb_pkg::SRCH_IDLE:
            begin
                stat.busy = 1'b0;
                if (ctl.start)
                begin
                    // First probe goes out in the accepting cycle, unless the count is zero.
                    low_next  = '0;
                    high_next = count;
                    mid_next  = count >> 1;
                    key_next  = key;
                    rd_en     = (count != '0);
                end
            end
            stlb_pkg::SRCH_PROBE:
            begin
                low_next  = low_step;
                high_next = high_step;
                mid_next  = bound_sum[POS_W:1];
                rd_en     = range_open;
            end
            stlb_pkg::SRCH_FINISH:
            begin
                stat.done = 1'b1;
            end
            default:
            begin
                stat.busy = 1'b0;
            end
        endcase
    end

    assign rd_addr  = mid_next[IDX_W-1:0];
    assign position = low_reg;

endmodule

@@ bench/tb_sorted_table_lower_bound_top.sv @@
// Self-checking testbench for sorted_table_lower_bound_top: directed rows, then random phases.
// Query results are checked against a lower-bound predictor of its own; write beats update its shadow table.
// Depends on stlb_pkg and sorted_table_lower_bound_top.
`timescale 1ns / 100ps

module tb_sorted_table_lower_bound_top;

    localparam int DEPTH       = 1024;
    localparam int IDX_W       = 10;
    localparam int POS_W       = 11;
    localparam int VAL_W       = 32;
    localparam int DRAIN_CYC   = 20;
    localparam int RAND_ITEMS  = 400;
    localparam int CYCLE_LIMIT = 1000000;

    typedef enum int
    {
        ROW_CFG,
        ROW_WRITE,
        ROW_QUERY
    } row_kind_t;

    // One row of the directed part: a count setting, a table write or a query.
    typedef struct
    {
        row_kind_t              kind;
        int unsigned            arg;      // count or entry index
        logic signed [VAL_W-1:0] value;   // entry value or search key
        bit                     fixed;    // expected position typed in below
        logic [POS_W-1:0]       pos;
    } dir_row_t;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_stall;
    logic                     command;
    logic [IDX_W-1:0]         entry_index;
    logic signed [VAL_W-1:0]  entry_value;
    logic signed [VAL_W-1:0]  search_key;
    logic                     out_valid;
    logic                     out_stall;
    logic [POS_W-1:0]         position;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [POS_W-1:0]         entry_count;

    // Shadow copy of the block: table contents, written marks and count.
    logic signed [VAL_W-1:0]  shadow_table [DEPTH];
    bit                       entry_written [DEPTH];
    int unsigned              cur_count;
    logic [POS_W-1:0]         expected_pos [$];
    dir_row_t                 directed [$];

    int                       errors;
    int                       stall_left;
    bit                       calm;
    int unsigned              cycles;
    logic [POS_W-1:0]         want_pos;

    sorted_table_lower_bound_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .command     (command),
        .entry_index (entry_index),
        .entry_value (entry_value),
        .search_key  (search_key),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .position    (position),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .entry_count (entry_count)
    );

    // Clock with a 4 ns period.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL sorted_table_lower_bound_top");
            $finish;
        end
    end

    // Halving search over the shadow table, probing the midpoint each step.
    function automatic logic [POS_W-1:0] lower_bound_of(logic signed [VAL_W-1:0] key);
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        lo = 0;
        hi = (cur_count > DEPTH) ? DEPTH : cur_count;
        while (lo < hi)
        begin
            mid = (lo + hi) >> 1;
            if (!entry_written[mid])
            begin
                $error("search would probe unwritten entry %0d", mid);
                errors++;
            end
            if (shadow_table[mid] < key)
                lo = mid + 1;
            else
                hi = mid;
        end
        return lo[POS_W-1:0];
    endfunction

    function automatic dir_row_t mk_row(row_kind_t kind, int unsigned arg,
                                        logic signed [VAL_W-1:0] value,
                                        bit fixed, int unsigned pos);
        dir_row_t r;
        r.kind  = kind;
        r.arg   = arg;
        r.value = value;
        r.fixed = fixed;
        r.pos   = pos[POS_W-1:0];
        return r;
    endfunction

    // Presents one input beat after a random gap (none when calm) and updates the shadow state once accepted.
    task automatic push_beat(logic cmd, logic [IDX_W-1:0] idx, logic signed [VAL_W-1:0] val,
                             logic signed [VAL_W-1:0] key, bit fixed,
                             logic [POS_W-1:0] pos);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 13);
        repeat (gap)
        begin
            @(negedge clk);
            in_valid = 1'b0;
        end
        @(negedge clk);
        in_valid    = 1'b1;
        command     = cmd;
        entry_index = idx;
        entry_value = val;
        search_key  = key;
        do
            @(posedge clk);
        while (in_stall);
        if (cmd == stlb_pkg::CMD_WRITE)
        begin
            shadow_table[idx]  = val;
            entry_written[idx] = 1'b1;
        end
        else
            expected_pos.push_back(fixed ? pos : lower_bound_of(key));
    endtask

    // Holds the sender back until every expected position has come out.
    task automatic wait_drained();
        @(negedge clk);
        in_valid = 1'b0;
        while (expected_pos.size() != 0)
            @(posedge clk);
    endtask

    // Writes the entry count while the block is idle.
    task automatic set_count(int unsigned n);
        wait_drained();
        repeat (DRAIN_CYC) @(posedge clk);
        @(negedge clk);
        cfg_valid   = 1'b1;
        entry_count = n[POS_W-1:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        cur_count = n;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Writes entries 0 to n-1 in ascending order, either spread or dense with repeats.
    task automatic fill_sorted(int unsigned n);
        longint cur;
        longint step_max;
        if (n == 0)
            return;
        if ($urandom_range(0, 1) == 1)
        begin
            step_max = 64'hFFFF_FFFF / (n + 1);
            cur = -64'sd2147483648 + $urandom_range(0, 32'(step_max));
        end
        else
        begin
            step_max = 3;
            cur = longint'($signed($urandom()));
        end
        for (int unsigned i = 0; i < n; i++)
        begin
            if (cur > 64'sd2147483647)
                cur = 64'sd2147483647;
            push_beat(stlb_pkg::CMD_WRITE, i[IDX_W-1:0], cur[VAL_W-1:0], $urandom(),
                      1'b0, '0);
            cur += $urandom_range(0, 32'(step_max));
        end
    endtask

    // Search key: half the time near a table entry, otherwise an extreme or anything at all.
    function automatic logic signed [VAL_W-1:0] pick_key(int unsigned n);
        int unsigned j;
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return {1'b1, {(VAL_W-1){1'b0}}};
            2: return {1'b0, {(VAL_W-1){1'b1}}};
            default:
            begin
                if (n == 0)
                    return $urandom();
                j = $urandom_range(0, n - 1);
                return shadow_table[j] + VAL_W'($urandom_range(0, 2)) - 1;
            end
        endcase
    endfunction

    // Result checker: each accepted position beat against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_pos.size() == 0)
            begin
                $error("unexpected position beat: actual %0d", position);
                errors++;
            end
            else
            begin
                want_pos = expected_pos.pop_front();
                if (position !== want_pos)
                begin
                    $error("position mismatch: expected %0d, actual %0d", want_pos, position);
                    errors++;
                end
            end
            stall_left = calm ? 0 : $urandom_range(0, 13);
        end
    end

    // Receiver stall, drawn afresh after every accepted beat.
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            out_stall  = 1'b1;
            stall_left = stall_left - 1;
        end
        else
            out_stall = 1'b0;
    end

    // Stimulus.
    initial
    begin
        logic signed [VAL_W-1:0] vmin;
        logic signed [VAL_W-1:0] vmax;
        int unsigned             rand_items;
        int unsigned             cnt;
        int unsigned             n;
        int unsigned             m;

        vmin        = {1'b1, {(VAL_W-1){1'b0}}};
        vmax        = {1'b0, {(VAL_W-1){1'b1}}};
        clk         = 1'b0;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        command     = stlb_pkg::CMD_WRITE;
        entry_index = '0;
        entry_value = '0;
        search_key  = '0;
        out_stall   = 1'b0;
        cfg_valid   = 1'b0;
        entry_count = '0;
        errors      = 0;
        stall_left  = 0;
        calm        = 1'b0;
        cycles      = 0;
        cur_count   = 0;
        for (int i = 0; i < DEPTH; i++)
            entry_written[i] = 1'b0;

        // Directed rows: empty table, extremes of value and key, a single entry,
        // a zero count, an unsorted table, then the full depth and a count beyond it.
        directed.push_back(mk_row(ROW_QUERY, 0, 0, 1'b1, 0));
        directed.push_back(mk_row(ROW_WRITE, 0, vmin, 1'b0, 0));
        directed.push_back(mk_row(ROW_WRITE, 1, -5, 1'b0, 0));
        directed.push_back(mk_row(ROW_WRITE, 2, 0, 1'b0, 0));
        directed.push_back(mk_row(ROW_WRITE, 3, 7, 1'b0, 0));
        directed.push_back(mk_row(ROW_WRITE, 4, vmax, 1'b0, 0));
        directed.push_back(mk_row(ROW_WRITE, DEPTH - 1, vmax, 1'b0, 0));
        directed.push_back(mk_row(ROW_CFG, 5, 0, 1'b0, 0));
        directed.push_back(mk_row(ROW_QUERY, 0, vmin, 1'b1, 0));
        directed.push_back(mk_row(ROW_QUERY, 0, vmax, 1'b1, 4));
        directed.push_back(mk_row(ROW_QUERY, 0, -5, 1'b0, 0));
        directed.push_back(mk_row(ROW_QUERY, 0, 1, 1'b0, 0));
        directed.push_back(mk_row(ROW_QUERY, 0, 8, 1'b0, 0));
        directed.push_back(mk_row(ROW_QUERY, 0, -6, 1'b0, 0));
        directed.push_back(mk_row(ROW_CFG, 1, 0, 1'b0, 0));
        directed.push_back(mk_row(ROW_QUERY, 0, vmin, 1'b1, 0));
        directed.push_back(mk_row(ROW_QUERY, 0, 0, 1'b0, 0));
        directed.push_back(mk_row(ROW_CFG, 0, 0, 1'b0, 0));
        directed.push_back(mk_row(ROW_QUERY, 0, vmax, 1'b1, 0));
        directed.push_back(mk_row(ROW_WRITE, 2, -100, 1'b0, 0));
        directed.push_back(mk_row(ROW_CFG, 5, 0, 1'b0, 0));
        directed.push_back(mk_row(ROW_QUERY, 0, -50, 1'b0, 0));
        directed.push_back(mk_row(ROW_QUERY, 0, 3, 1'b0, 0));

        // Full depth: only the entries on the leftmost and rightmost probe paths
        // are written, so extreme keys walk eleven and ten probes.
        directed.push_back(mk_row(ROW_WRITE, 8, 100, 1'b0, 0));
        directed.push_back(mk_row(ROW_WRITE, 16, 100, 1'b0, 0));
        directed.push_back(mk_row(ROW_WRITE, 32, 100, 1'b0, 0));
        directed.push_back(mk_row(ROW_WRITE, 64, 100, 1'b0, 0));
        directed.push_back(mk_row(ROW_WRITE, 128, 100, 1'b0, 0));
        directed.push_back(mk_row(ROW_WRITE, 256, 100, 1'b0, 0));
        directed.push_back(mk_row(ROW_WRITE, 512, 100, 1'b0, 0));
        directed.push_back(mk_row(ROW_WRITE, 768, 100, 1'b0, 0));
        directed.push_back(mk_row(ROW_WRITE, 896, 100, 1'b0, 0));
        directed.push_back(mk_row(ROW_WRITE, 960, 100, 1'b0, 0));
        directed.push_back(mk_row(ROW_WRITE, 992, 100, 1'b0, 0));
        directed.push_back(mk_row(ROW_WRITE, 1008, 100, 1'b0, 0));
        directed.push_back(mk_row(ROW_WRITE, 1016, 100, 1'b0, 0));
        directed.push_back(mk_row(ROW_WRITE, 1020, 100, 1'b0, 0));
        directed.push_back(mk_row(ROW_WRITE, 1022, 100, 1'b0, 0));
        directed.push_back(mk_row(ROW_CFG, DEPTH, 0, 1'b0, 0));
        directed.push_back(mk_row(ROW_QUERY, 0, vmin, 1'b1, 0));
        directed.push_back(mk_row(ROW_QUERY, 0, vmax, 1'b1, DEPTH - 1));
        directed.push_back(mk_row(ROW_QUERY, 0, 50, 1'b0, 0));
        directed.push_back(mk_row(ROW_CFG, (1 << POS_W) - 1, 0, 1'b0, 0));
        directed.push_back(mk_row(ROW_QUERY, 0, vmin, 1'b1, 0));
        directed.push_back(mk_row(ROW_QUERY, 0, vmax, 1'b1, DEPTH - 1));

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Walk the directed rows.
        foreach (directed[i])
        begin
            case (directed[i].kind)
                ROW_CFG:
                    set_count(directed[i].arg);
                ROW_WRITE:
                    push_beat(stlb_pkg::CMD_WRITE, directed[i].arg[IDX_W-1:0],
                              directed[i].value, $urandom(), 1'b0, '0);
                default:
                    push_beat(stlb_pkg::CMD_QUERY, IDX_W'($urandom()), $urandom(),
                              directed[i].value, directed[i].fixed, directed[i].pos);
            endcase
        end

        // Random phases: a count, a sorted fill, then queries mixed with stray writes.
        rand_items = 0;
        while (rand_items < RAND_ITEMS)
        begin
            calm = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) == 0)
                cnt = 0;
            else
                cnt = $urandom_range(1, 48);
            set_count(cnt);
            n = cnt;
            fill_sorted(n);
            rand_items += n;

            // Now and then spoil the order of a few entries.
            if (n > 1 && $urandom_range(0, 4) == 0)
            begin
                repeat ($urandom_range(1, 3))
                    push_beat(stlb_pkg::CMD_WRITE, IDX_W'($urandom_range(0, n - 1)),
                              $urandom(), $urandom(), 1'b0, '0);
            end

            m = $urandom_range(10, 40);
            for (int unsigned k = 0; k < m; k++)
            begin
                if ($urandom_range(0, 15) == 0)
                    wait_drained();
                if ($urandom_range(0, 9) == 0)
                    push_beat(stlb_pkg::CMD_WRITE, IDX_W'($urandom()), $urandom(),
                              $urandom(), 1'b0, '0);
                else
                    push_beat(stlb_pkg::CMD_QUERY, IDX_W'($urandom()), $urandom(),
                              pick_key(n), 1'b0, '0);
                rand_items++;
            end
        end

        // Drain and report.
        wait_drained();
        repeat (DRAIN_CYC) @(posedge clk);
        if (errors == 0)
            $display("PASS sorted_table_lower_bound_top");
        else
            $display("FAIL sorted_table_lower_bound_top");
        $finish;
    end

endmodule
